@@ sv/ubr_pkg.sv @@
// shared types, constants and helpers for the utf-8 boundary reassembler
package ubr_pkg;

  localparam int DEF_PENDING_BYTES = 8;
  localparam int MAX_RESULTS       = 8;

  localparam logic [7:0] ASCII_MASK  = 8'h80;
  localparam logic [7:0] LEAD2_MASK  = 8'hE0;
  localparam logic [7:0] LEAD2_VALUE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK  = 8'hF0;
  localparam logic [7:0] LEAD3_VALUE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK  = 8'hF8;
  localparam logic [7:0] LEAD4_VALUE = 8'hF0;
  localparam logic [1:0] CONT_TAG    = 2'b10;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_FLUSH   = 2'd1,
    OP_DISCARD = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic scan_en;
    logic scan_end;
    logic emit_en;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic emit_left_zero;
    logic out_free;
  } dp_status_t;

  // sequence length announced by a lead byte, stray bytes count as one
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    if ((b & ASCII_MASK) == 8'h00) begin
      len = 3'd1;
    end else if ((b & LEAD2_MASK) == LEAD2_VALUE) begin
      len = 3'd2;
    end else if ((b & LEAD3_MASK) == LEAD3_VALUE) begin
      len = 3'd3;
    end else if ((b & LEAD4_MASK) == LEAD4_VALUE) begin
      len = 3'd4;
    end else begin
      len = 3'd1;
    end
    return len;
  endfunction

endpackage

@@ sv/utf8_boundary_reassembler.sv @@
// Holds back an unfinished UTF-8 tail: a push scans the pending bytes plus the new one and
// emits the bytes up to the end of the last complete sequence, at most eight; a flush emits
// up to eight pending bytes as they are, a discard clears them. One transaction is worked at
// a time. A push runs an accept step, scan steps of one sequence or skipped byte each, a
// step that closes the scan, the emission of its bytes while the output is not stalled, and a
// commit step; a flush skips the scan steps and a discard needs only the accept step. The scan
// window steps by a whole sequence, or by one byte past a lead with a bad continuation.
module utf8_boundary_reassembler #(
  parameter int PENDING_BYTES = ubr_pkg::DEF_PENDING_BYTES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ubr_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ubr_pkg::out_item_t out_item_o
);
  import ubr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  ubr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (in_item_i.opcode),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  ubr_datapath #(
    .PENDING_BYTES (PENDING_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

endmodule

@@ sv/ubr_ctrl.sv @@
// controller state machine of the utf-8 boundary reassembler
module ubr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          opcode_i,
  input  ubr_pkg::dp_status_t status_i,
  output ubr_pkg::ctrl_cmd_t  cmd_o,
  output logic                in_stall_o
);
  import ubr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (opcode_i == OP_PUSH) begin
            state_d = ST_SCAN;
          end else if (opcode_i == OP_FLUSH) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_SCAN: begin
        if (status_i.scan_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.emit_left_zero) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      ST_SCAN: begin
        cmd_o.scan_en  = !status_i.scan_done;
        cmd_o.scan_end = status_i.scan_done;
      end
      ST_EMIT: begin
        cmd_o.commit  = status_i.emit_left_zero;
        cmd_o.emit_en = !status_i.emit_left_zero && status_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  a_emit_only_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_en |-> state_q == ST_EMIT && !status_i.emit_left_zero)
    else $error("emission outside the emit phase");

  a_commit_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> state_q == ST_IDLE)
    else $error("commit did not return to idle");

  a_scan_follows_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && opcode_i == OP_PUSH) |=> state_q == ST_SCAN)
    else $error("push transaction did not start a scan");

endmodule

@@ sv/ubr_datapath.sv @@
// pending store, scan window, counters and output register
module ubr_datapath #(
  parameter int PENDING_BYTES = ubr_pkg::DEF_PENDING_BYTES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ubr_pkg::in_item_t   in_item_i,
  input  ubr_pkg::ctrl_cmd_t  cmd_i,
  output ubr_pkg::dp_status_t status_o,
  output logic                out_valid_o,
  output ubr_pkg::out_item_t  out_item_o,
  input  logic                out_stall_i
);
  import ubr_pkg::*;

  localparam int CW = $clog2((PENDING_BYTES + 2 > MAX_RESULTS + 1) ?
                             PENDING_BYTES + 2 : MAX_RESULTS + 1);
  localparam int IW = $clog2(PENDING_BYTES + 1);

  logic [7:0]    buf_q [PENDING_BYTES+1];
  logic [7:0]    buf_d [PENDING_BYTES+1];
  logic [7:0]    win_q [PENDING_BYTES+1];
  logic [7:0]    win_d [PENDING_BYTES+1];
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] len_q, len_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] done_q, done_d;
  logic [CW-1:0] sent_q, sent_d;
  logic [CW-1:0] left_q, left_d;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_q, out_d;

  logic [2:0]    seq_len;
  logic [2:0]    shift_amt;
  logic [CW-1:0] remain;
  logic [CW-1:0] rest;
  logic          cont_ok;

  assign seq_len = lead_length(win_q[0]);
  assign remain  = len_q - pos_q;
  assign rest    = len_q - sent_q;

  always_comb begin
    cont_ok = 1'b1;
    for (int k = 1; k < 4; k++) begin
      if (3'(k) < seq_len && win_q[k][7:6] != CONT_TAG) begin
        cont_ok = 1'b0;
      end
    end
  end

  // a bad continuation skips only the lead byte
  assign shift_amt = cont_ok ? seq_len : 3'd1;

  assign status_o.scan_done      = (pos_q == len_q) || (CW'(seq_len) > remain);
  assign status_o.emit_left_zero = (left_q == '0);
  assign status_o.out_free       = !out_valid_q || !out_stall_i;

  always_comb begin
    buf_d       = buf_q;
    win_d       = win_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    pos_d       = pos_q;
    done_d      = done_q;
    sent_d      = sent_q;
    left_d      = left_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (cmd_i.accept) begin
      if (in_item_i.opcode == OP_PUSH) begin
        buf_d[cnt_q[IW-1:0]] = in_item_i.data_byte;
        for (int i = 0; i <= PENDING_BYTES; i++) begin
          win_d[i] = (IW'(i) == cnt_q[IW-1:0]) ? in_item_i.data_byte : buf_q[i];
        end
        len_d  = cnt_q + CW'(1);
        pos_d  = '0;
        done_d = '0;
      end else if (in_item_i.opcode == OP_FLUSH) begin
        len_d  = cnt_q;
        sent_d = (cnt_q > CW'(MAX_RESULTS)) ? CW'(MAX_RESULTS) : cnt_q;
        left_d = (cnt_q > CW'(MAX_RESULTS)) ? CW'(MAX_RESULTS) : cnt_q;
      end else if (in_item_i.opcode == OP_DISCARD) begin
        cnt_d = '0;
      end
    end

    if (cmd_i.scan_en) begin
      for (int i = 0; i <= PENDING_BYTES; i++) begin
        case (shift_amt)
          3'd1: if (i + 1 <= PENDING_BYTES) win_d[i] = win_q[i+1];
          3'd2: if (i + 2 <= PENDING_BYTES) win_d[i] = win_q[i+2];
          3'd3: if (i + 3 <= PENDING_BYTES) win_d[i] = win_q[i+3];
          3'd4: if (i + 4 <= PENDING_BYTES) win_d[i] = win_q[i+4];
          default: win_d[i] = win_q[i];
        endcase
      end
      pos_d = pos_q + CW'(shift_amt);
      if (cont_ok) begin
        done_d = pos_q + CW'(shift_amt);
      end
    end

    if (cmd_i.scan_end) begin
      sent_d = (done_q > CW'(MAX_RESULTS)) ? CW'(MAX_RESULTS) : done_q;
      left_d = (done_q > CW'(MAX_RESULTS)) ? CW'(MAX_RESULTS) : done_q;
    end

    if (cmd_i.emit_en) begin
      out_valid_d       = 1'b1;
      out_d.out_byte    = buf_q[0];
      out_d.last_of_run = (left_q == CW'(1));
      for (int i = 0; i < PENDING_BYTES; i++) begin
        buf_d[i] = buf_q[i+1];
      end
      left_d = left_q - CW'(1);
    end

    // an over-long tail is dropped whole
    if (cmd_i.commit) begin
      cnt_d = (rest > CW'(PENDING_BYTES)) ? '0 : rest;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    win_q <= win_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      len_q       <= '0;
      pos_q       <= '0;
      done_q      <= '0;
      sent_q      <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      len_q       <= len_d;
      pos_q       <= pos_d;
      done_q      <= done_d;
      sent_q      <= sent_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(PENDING_BYTES))
    else $error("pending count beyond capacity");

  a_sent_within_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> sent_q <= len_q)
    else $error("more bytes sent than held");

  a_last_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_en && left_q == CW'(1)) |=> out_valid_q && out_q.last_of_run)
    else $error("final byte of a run not marked last");

endmodule

@@ verif/utf8_boundary_reassembler_test.sv @@
// self-checking testbench for the utf-8 boundary reassembler
`timescale 1ns / 1ps

module utf8_boundary_reassembler_test;
  import ubr_pkg::*;

  localparam int          HELD_MAX    = DEF_PENDING_BYTES;
  localparam int          EMIT_CAP    = MAX_RESULTS;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam int          HOLD_CYCLES = 80;
  localparam int          QUIET_LIMIT = 1000;
  localparam int          DRAIN_WAIT  = 40;
  localparam int          PHASE_ITEMS = 80;

  typedef logic [7:0] seq_q_t[$];

  // tracks the held tail and the bytes still due from the block
  class reassembly_scoreboard;
    logic [7:0]  held[HELD_MAX];
    int unsigned held_cnt;
    out_item_t   due_q[$];
    int unsigned mismatches;

    function new();
      held_cnt   = 0;
      mismatches = 0;
    endfunction

    function int unsigned seq_len(logic [7:0] b);
      casez (b)
        8'b0???????: return 1;
        8'b110?????: return 2;
        8'b1110????: return 3;
        8'b11110???: return 4;
        default:     return 1;
      endcase
    endfunction

    function void note_input(in_item_t it);
      logic [7:0]  scan[HELD_MAX+1];
      int unsigned len, pos, done, sent, rest, sl;
      bit          good;
      out_item_t   e;
      if (it.opcode == OP_DISCARD) begin
        held_cnt = 0;
      end else if (it.opcode == OP_PUSH || it.opcode == OP_FLUSH) begin
        len = held_cnt;
        for (int k = 0; k < len; k++) scan[k] = held[k];
        if (it.opcode == OP_FLUSH) begin
          done = len;
        end else begin
          scan[len] = it.data_byte;
          len++;
          pos  = 0;
          done = 0;
          while (pos < len) begin
            sl = seq_len(scan[pos]);
            if (pos + sl > len) break;
            good = 1'b1;
            for (int i = 1; i < sl; i++) begin
              if (scan[pos+i][7:6] != CONT_TAG) good = 1'b0;
            end
            if (good) begin
              pos += sl;
              done = pos;
            end else begin
              pos++;
            end
          end
        end
        sent = (done < EMIT_CAP) ? done : EMIT_CAP;
        for (int k = 0; k < sent; k++) begin
          e.out_byte    = scan[k];
          e.last_of_run = (k + 1 == sent);
          due_q.push_back(e);
        end
        rest = len - sent;
        // an over-long tail is dropped whole
        if (rest <= HELD_MAX) begin
          for (int k = 0; k < rest; k++) held[k] = scan[sent+k];
          held_cnt = rest;
        end else begin
          held_cnt = 0;
        end
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (due_q.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected byte %h last %b", $realtime, got.out_byte, got.last_of_run);
        mismatches++;
      end else begin
        want = due_q.pop_front();
        if (got.out_byte !== want.out_byte || got.last_of_run !== want.last_of_run) begin
          if (mismatches < 10)
            $display("%0t: expected byte %h last %b, got byte %h last %b", $realtime,
                     want.out_byte, want.last_of_run, got.out_byte, got.last_of_run);
          mismatches++;
        end
      end
    endfunction

    function int unsigned outstanding();
      return due_q.size();
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  reassembly_scoreboard sb;
  int unsigned src_idle_pct;
  int unsigned dst_idle_pct;
  int unsigned items_sent;
  bit          hold_req;

  utf8_boundary_reassembler #(
    .PENDING_BYTES(HELD_MAX)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_item_o);
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_input(in_item_i);
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) begin
          out_stall_i = 1'b1;
          @(negedge clk_i);
        end
      end
      out_stall_i = ($urandom_range(99) < dst_idle_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_op(input logic [1:0] op, input logic [7:0] b);
    in_item_t it;
    it.opcode    = op;
    it.data_byte = b;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_item_i  = it;
    do @(posedge clk_i); while (in_stall_o);
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic push_seq(input seq_q_t seq);
    foreach (seq[k]) send_op(OP_PUSH, seq[k]);
  endtask

  // well-formed character of n bytes with random payload bits
  function automatic seq_q_t rand_char(int unsigned n);
    seq_q_t seq;
    logic [7:0] r;
    r = 8'($urandom_range(255));
    case (n)
      1:       seq.push_back({1'b0, r[6:0]});
      2:       seq.push_back({3'b110, r[4:0]});
      3:       seq.push_back({4'b1110, r[3:0]});
      default: seq.push_back({5'b11110, r[2:0]});
    endcase
    for (int k = 1; k < n; k++) begin
      r = 8'($urandom_range(255));
      seq.push_back({CONT_TAG, r[5:0]});
    end
    return seq;
  endfunction

  initial begin : stimulus
    seq_q_t      seq;
    int unsigned pick, rand_base, cut;
    logic [7:0]  r;

    sb           = new();
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_item_i    = '0;
    src_idle_pct = 24;
    dst_idle_pct = 50;
    items_sent   = 0;
    hold_req     = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // empty flush, empty discard, ignored opcode
    send_op(OP_FLUSH, 8'h00);
    send_op(OP_DISCARD, 8'hFF);
    send_op(OP_UNUSED, 8'hFF);
    // ascii low end, invalid lead
    send_op(OP_PUSH, 8'h00);
    send_op(OP_PUSH, 8'hFF);
    push_seq('{8'hC3, 8'hA9});
    push_seq('{8'hE2, 8'h82, 8'hAC});
    push_seq('{8'hF0, 8'h9F, 8'h98, 8'h80});
    // broken continuation skips the lead
    push_seq('{8'hC3, 8'h41});
    // eight held bytes then a completion: more than the emission cap at once
    push_seq('{8'hF0, 8'hF0, 8'hF0, 8'hF0, 8'hF0, 8'hF0, 8'hE2, 8'h82, 8'hAC});
    send_op(OP_FLUSH, 8'h5A);

    rand_base = items_sent;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin src_idle_pct = 24; dst_idle_pct = 50; end
        1:       begin src_idle_pct = 50; dst_idle_pct = 24; end
        default: begin src_idle_pct = 0;  dst_idle_pct = 0;  end
      endcase
      if (phase != 1) hold_req = 1'b1;
      while (items_sent < rand_base + PHASE_ITEMS * (phase + 1)) begin
        pick = $urandom_range(99);
        r    = 8'($urandom_range(255));
        if (pick < 55) begin
          push_seq(rand_char($urandom_range(1, 4)));
        end else if (pick < 65) begin
          seq = rand_char($urandom_range(2, 4));
          cut = $urandom_range(1, seq.size() - 1);
          repeat (cut) void'(seq.pop_back());
          push_seq(seq);
        end else if (pick < 75) begin
          send_op(OP_PUSH, r);
        end else if (pick < 83) begin
          send_op(OP_FLUSH, r);
        end else if (pick < 88) begin
          send_op(OP_DISCARD, r);
        end else if (pick < 91) begin
          send_op(OP_UNUSED, r);
        end else begin
          // run of four-byte leads: nothing completes, tail grows past the store
          seq.delete();
          repeat ($urandom_range(8, 10)) begin
            r = 8'($urandom_range(255));
            seq.push_back({5'b11110, r[2:0]});
          end
          push_seq(seq);
        end
      end
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/ubr_pkg.sv
sv/ubr_ctrl.sv
sv/ubr_datapath.sv
sv/utf8_boundary_reassembler.sv
verif/utf8_boundary_reassembler_test.sv
